### rtl/core/caseless_find_replace_stream_core_defines.svh
// Assertion macros shared by the caseless find-and-replace stream core.
`ifndef CASELESS_FIND_REPLACE_STREAM_CORE_DEFINES_SVH
`define CASELESS_FIND_REPLACE_STREAM_CORE_DEFINES_SVH

`ifndef SYNTH
// Check cond at every edge outside reset.
`define CFRS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that ante implies cons in the same cycle.
`define CFRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that ante implies cons in the next cycle.
`define CFRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CFRS_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define CFRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define CFRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/core/cfrs_pkg.sv
// Types and constants shared by the caseless find-and-replace stream core.
package cfrs_pkg;

   // Window and command byte capacity
   localparam int CmdBytes = 16;
   localparam logic [4:0] SwapMax = 5'd16;

   // Command queue geometry
   localparam int QDepth = 4;
   localparam int QPtrW  = 2;
   localparam int QCntW  = 3;

   // Register indexes on the configuration port
   localparam logic [2:0] CsrMatchLo  = 3'd0;
   localparam logic [2:0] CsrMatchHi  = 3'd1;
   localparam logic [2:0] CsrMatchLen = 3'd2;
   localparam logic [2:0] CsrSwapLo   = 3'd3;
   localparam logic [2:0] CsrSwapHi   = 3'd4;
   localparam logic [2:0] CsrSwapLen  = 3'd5;

   // Configuration as seen by the front and back parts
   typedef struct packed {
      logic [63:0] match_lo;
      logic [63:0] match_hi;
      logic [4:0]  match_len;
      logic [63:0] swap_lo;
      logic [63:0] swap_hi;
      logic [4:0]  swap_len;
   } cfg_type;

   // One emit command: either the replacement or a run of window bytes
   typedef struct packed {
      logic                          use_swap;
      logic [CmdBytes-1:0][7:0]      bytes;
      logic [4:0]                    count;
      logic                          is_last;
      logic                          any;
   } cmd_type;

   // Queue status toward the front and back
   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

### rtl/core/cfrs_front.sv
// Front part: window, caseless compare and emit-command builder.
module cfrs_front #(
   parameter int MAX_PATTERN = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cfrs_pkg::cfg_type cfg,
   input  logic              len_write,
   input  logic              accept,
   input  logic [7:0]        byte_in,
   input  logic              last_in,
   output logic              push,
   output cfrs_pkg::cmd_type cmd
);

   localparam int PatCap = (MAX_PATTERN < cfrs_pkg::CmdBytes) ? MAX_PATTERN
                                                               : cfrs_pkg::CmdBytes;
   localparam int FillW = $clog2(PatCap + 1);
   localparam logic [4:0] PatCapLen = 5'(PatCap);
   localparam logic [7:0] UpperA    = 8'h41;
   localparam logic [7:0] UpperZ    = 8'h5a;
   localparam logic [7:0] CaseDelta = 8'h20;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return ((c >= UpperA) && (c <= UpperZ)) ? (c + CaseDelta) : c;
   endfunction

   logic [cfrs_pkg::CmdBytes-1:0][7:0] win_ff, win_in;
   logic [FillW-1:0]                   fill_ff, fill_in;
   logic                               replaced_ff, replaced_in;

   logic [cfrs_pkg::CmdBytes-1:0][7:0] pat_bytes;
   logic [cfrs_pkg::CmdBytes-1:0][7:0] wnew;
   logic [cfrs_pkg::CmdBytes-1:0]      eq;
   logic [4:0]                         len;
   logic [4:0]                         swap_len;
   logic [4:0]                         fill_ext;
   logic                               full;
   logic                               hit;

   assign pat_bytes = {cfg.match_hi, cfg.match_lo};
   assign len       = (cfg.match_len > PatCapLen) ? PatCapLen : cfg.match_len;
   assign swap_len  = (cfg.swap_len > cfrs_pkg::SwapMax) ? cfrs_pkg::SwapMax : cfg.swap_len;
   assign fill_ext  = 5'(fill_ff);
   assign full      = ((fill_ext + 5'd1) == len);

   // Place the new byte and compare the window against the pattern
   always_comb begin
      for (int k = 0; k < cfrs_pkg::CmdBytes; k++) begin
         wnew[k] = (int'(fill_ff) == k) ? byte_in : win_ff[k];
         eq[k]   = (k >= int'(len)) || (fold_case(wnew[k]) == fold_case(pat_bytes[k]));
      end
   end
   assign hit = &eq;

   // Build the emit command and the next window state
   always_comb begin
      win_in       = win_ff;
      fill_in      = fill_ff;
      replaced_in  = replaced_ff;
      cmd.use_swap = 1'b0;
      cmd.bytes    = wnew;
      cmd.count    = 5'd0;
      cmd.is_last  = last_in;
      cmd.any      = 1'b0;
      push         = 1'b0;
      if (accept) begin
         priority if (len == 5'd0) begin
            cmd.bytes[0] = byte_in;
            cmd.count    = 5'd1;
            fill_in      = '0;
         end else if (full && hit) begin
            cmd.use_swap = 1'b1;
            cmd.count    = swap_len;
            replaced_in  = 1'b1;
            fill_in      = '0;
         end else if (full) begin
            // emit the oldest byte, or the whole window at end of text
            cmd.count = last_in ? len : 5'd1;
            for (int k = 0; k < cfrs_pkg::CmdBytes - 1; k++) begin
               win_in[k] = wnew[k + 1];
            end
            win_in[cfrs_pkg::CmdBytes-1] = wnew[cfrs_pkg::CmdBytes-1];
            fill_in = FillW'(len - 5'd1);
         end else begin
            win_in    = wnew;
            fill_in   = fill_ff + 1'b1;
            cmd.count = last_in ? (fill_ext + 5'd1) : 5'd0;
         end
         cmd.any = last_in && (replaced_ff || ((len != 5'd0) && full && hit));
         if (last_in) begin
            fill_in     = '0;
            replaced_in = 1'b0;
         end
         push = (cmd.count != 5'd0) || last_in;
      end
      if (len_write) begin
         fill_in = '0;
      end
   end

   // Hold fill level and replace flag
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         replaced_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         replaced_ff <= replaced_in;
      end
   end

   // Window bytes carry no reset
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

### rtl/core/cfrs_queue.sv
// Short command queue between the front and back parts.
module cfrs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cfrs_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output cfrs_pkg::cmd_type      head,
   output cfrs_pkg::q_status_type status
);

   cfrs_pkg::cmd_type             entry_ff [cfrs_pkg::QDepth];
   logic [cfrs_pkg::QPtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cfrs_pkg::QPtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cfrs_pkg::QCntW-1:0]    cnt_ff, cnt_in;

   assign head             = entry_ff[rd_ptr_ff];
   assign status.not_empty = (cnt_ff != '0);
   assign status.full      = (cnt_ff == cfrs_pkg::QCntW'(cfrs_pkg::QDepth));

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/cfrs_back.sv
// Back part: expands queued commands into output items, one byte a cycle while rsp_stall is low.
module cfrs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  cfrs_pkg::cfg_type      cfg,
   input  cfrs_pkg::cmd_type      head,
   input  cfrs_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_byte_out,
   output logic                   rsp_byte_present,
   output logic                   rsp_final_result,
   output logic                   rsp_any_replaced
);

   logic [3:0]                         idx_ff, idx_in;
   logic                               valid_ff, valid_in;
   logic [7:0]                         byte_ff;
   logic                               present_ff;
   logic                               final_ff;
   logic                               any_ff;

   logic [cfrs_pkg::CmdBytes-1:0][7:0] swap_bytes;
   logic                               slot_free;
   logic                               take;
   logic                               at_end;
   logic                               present;
   logic [7:0]                         cur_byte;

   assign swap_bytes = {cfg.swap_hi, cfg.swap_lo};
   assign slot_free  = !valid_ff || !rsp_stall;
   assign take       = q_status.not_empty && slot_free;
   assign present    = (head.count != 5'd0);
   assign at_end     = !present || ((5'(idx_ff) + 5'd1) == head.count);
   assign pop        = take && at_end;

   // Select the byte at the current position of the head command
   always_comb begin
      if (!present) begin
         cur_byte = 8'd0;
      end else if (head.use_swap) begin
         cur_byte = swap_bytes[idx_ff];
      end else begin
         cur_byte = head.bytes[idx_ff];
      end
   end

   // Step through the command; wrap on its last byte
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      if (take) begin
         idx_in   = at_end ? 4'd0 : (idx_ff + 4'd1);
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Load the output register when it is free
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff    <= cur_byte;
         present_ff <= present;
         final_ff   <= head.is_last && at_end;
         any_ff     <= head.any && at_end;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_byte_out     = byte_ff;
   assign rsp_byte_present = present_ff;
   assign rsp_final_result = final_ff;
   assign rsp_any_replaced = any_ff;

endmodule

### rtl/core/caseless_find_replace_stream_core.sv
// Top level of the caseless find-and-replace stream core.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_byte_in, req_end_of_text
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_byte_out, rsp_byte_present,
//           |           |                      | rsp_final_result, rsp_any_replaced
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One input byte is taken per cycle while req_stall is low; the front compares the window in the same cycle.
// The back emits one output byte per cycle while rsp_stall is low, so a replacement or an
// end-of-text flush of n bytes keeps the back busy until all n bytes are out; a four-entry
// command queue absorbs this and req_stall rises only while that queue is full.
// Reset is synchronous and clears configuration, fill level, replace flag, queue and output valid.
// csr_ready is always high; a match length write empties the window.
`include "caseless_find_replace_stream_core_defines.svh"

module caseless_find_replace_stream_core #(
   parameter int MAX_PATTERN = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_byte_present,
   output logic        rsp_final_result,
   output logic        rsp_any_replaced,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cfrs_pkg::cfg_type      cfg_ff, cfg_in;
   cfrs_pkg::cmd_type      push_cmd;
   cfrs_pkg::cmd_type      head;
   cfrs_pkg::q_status_type q_status;
   logic                   csr_write;
   logic                   len_write;
   logic                   accept;
   logic                   push;
   logic                   pop;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign len_write = csr_write && (csr_index == cfrs_pkg::CsrMatchLen);
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            cfrs_pkg::CsrMatchLo:  cfg_in.match_lo  = csr_wdata;
            cfrs_pkg::CsrMatchHi:  cfg_in.match_hi  = csr_wdata;
            cfrs_pkg::CsrMatchLen: cfg_in.match_len = csr_wdata[4:0];
            cfrs_pkg::CsrSwapLo:   cfg_in.swap_lo   = csr_wdata;
            cfrs_pkg::CsrSwapHi:   cfg_in.swap_hi   = csr_wdata;
            cfrs_pkg::CsrSwapLen:  cfg_in.swap_len  = csr_wdata[4:0];
            default:               cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfrs_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .len_write (len_write),
      .accept    (accept),
      .byte_in   (req_byte_in),
      .last_in   (req_end_of_text),
      .push      (push),
      .cmd       (push_cmd)
   );

   cfrs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   cfrs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head             (head),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_byte_present (rsp_byte_present),
      .rsp_final_result (rsp_final_result),
      .rsp_any_replaced (rsp_any_replaced)
   );

   // Empty item only as the end-of-stream marker
   `CFRS_ASSERT_IMPLY(a_empty_is_final, clock, reset, rsp_valid && !rsp_byte_present, rsp_final_result, "empty item without final mark")
   // Replace report only on the final item
   `CFRS_ASSERT_IMPLY(a_any_on_final, clock, reset, rsp_valid && rsp_any_replaced, rsp_final_result, "replace report on non-final item")
   // Empty item carries a zero byte
   `CFRS_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && !rsp_byte_present, rsp_byte_out == 8'd0, "empty item with nonzero byte")
   // Queue never pops while empty
   `CFRS_ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, q_status.not_empty, "queue pop while empty")
   // A push into a full queue cannot happen
   `CFRS_ASSERT_IMPLY(a_push_room, clock, reset, push, !q_status.full, "queue push while full")

endmodule

### tb/sv/tb_caseless_find_replace_stream_core.sv
// Self-checking testbench for the caseless find-and-replace stream core.
module tb_caseless_find_replace_stream_core;

   localparam int PatCap  = 16;
   localparam int SwapCap = 16;

   typedef logic [7:0] text_q_type [$];

   // One rewritten output item as the block should deliver it
   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
      logic       any;
   } rewrite_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_byte_out;
   logic        rsp_byte_present;
   logic        rsp_final_result;
   logic        rsp_any_replaced;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = cfrs_pkg::CsrMatchLo;
   logic [63:0] csr_wdata = 64'd0;

   // Shadow of the pattern and replacement registers and the look-ahead window
   logic [63:0] pat_lo = 64'd0;
   logic [63:0] pat_hi = 64'd0;
   logic [4:0]  pat_len_reg = 5'd0;
   logic [63:0] rep_lo = 64'd0;
   logic [63:0] rep_hi = 64'd0;
   logic [4:0]  rep_len_reg = 5'd0;
   logic [7:0]  window [PatCap];
   int          window_fill = 0;
   bit          replaced_any = 1'b0;

   rewrite_type rewrite_q [$];
   text_q_type  text_buf;
   int          mismatch_count = 0;
   int          idle_pct = 33;
   int          stall_pct = 66;

   caseless_find_replace_stream_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_byte_present (rsp_byte_present),
      .rsp_final_result (rsp_final_result),
      .rsp_any_replaced (rsp_any_replaced),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Random backpressure on the result side
   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   function automatic logic [7:0] fold_case(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] byte_lane(logic [63:0] lo, logic [63:0] hi, int k);
      return (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
   endfunction

   // Flip the case of a letter half of the time
   function automatic logic [7:0] vary_case(logic [7:0] c);
      logic [7:0] low;
      low = c | 8'h20;
      if (low >= "a" && low <= "z" && $urandom_range(0, 1) == 1) return c ^ 8'h20;
      return c;
   endfunction

   // Any byte with a chance of raw_pct percent, else a letter a..d in either case
   function automatic logic [7:0] pick_byte(int raw_pct);
      if ($urandom_range(0, 99) < raw_pct) return 8'($urandom_range(0, 255));
      return vary_case(8'h61 + 8'($urandom_range(0, 3)));
   endfunction

   function automatic void apply_csr(logic [2:0] idx, logic [63:0] d);
      case (idx)
         cfrs_pkg::CsrMatchLo:  pat_lo = d;
         cfrs_pkg::CsrMatchHi:  pat_hi = d;
         cfrs_pkg::CsrMatchLen: begin
            pat_len_reg = d[4:0];
            window_fill = 0;
         end
         cfrs_pkg::CsrSwapLo:   rep_lo = d;
         cfrs_pkg::CsrSwapHi:   rep_hi = d;
         cfrs_pkg::CsrSwapLen:  rep_len_reg = d[4:0];
         default: ;
      endcase
   endfunction

   // Work out the output items one accepted input byte causes
   function automatic void predict_rewrite(logic [7:0] b, logic eot);
      rewrite_type step_out [32];
      int       n;
      int       mlen;
      int       slen;
      int       k;
      bit       hit;
      n = 0;
      mlen = (pat_len_reg > PatCap) ? PatCap : int'(pat_len_reg);
      slen = (rep_len_reg > SwapCap) ? SwapCap : int'(rep_len_reg);
      if (mlen == 0) begin
         window_fill = 0;
         step_out[n] = {b, 1'b1, 1'b0, 1'b0};
         n = n + 1;
      end else begin
         if (window_fill >= mlen) window_fill = 0;
         window[window_fill] = b;
         window_fill = window_fill + 1;
         if (window_fill == mlen) begin
            hit = 1'b1;
            for (k = 0; k < mlen; k++) begin
               if (fold_case(window[k]) != fold_case(byte_lane(pat_lo, pat_hi, k))) hit = 1'b0;
            end
            if (hit) begin
               // emit the replacement and empty the window
               for (k = 0; k < slen; k++) begin
                  step_out[n] = {byte_lane(rep_lo, rep_hi, k), 1'b1, 1'b0, 1'b0};
                  n = n + 1;
               end
               replaced_any = 1'b1;
               window_fill = 0;
            end else begin
               // emit the oldest byte and advance the window
               step_out[n] = {window[0], 1'b1, 1'b0, 1'b0};
               n = n + 1;
               for (k = 0; k < window_fill - 1; k++) window[k] = window[k+1];
               window_fill = window_fill - 1;
            end
         end
      end
      if (eot) begin
         // flush the window and mark the end of the stream
         for (k = 0; k < window_fill; k++) begin
            step_out[n] = {window[k], 1'b1, 1'b0, 1'b0};
            n = n + 1;
         end
         window_fill = 0;
         if (n == 0) begin
            step_out[n] = {8'h00, 1'b0, 1'b0, 1'b0};
            n = n + 1;
         end
         step_out[n-1].last = 1'b1;
         step_out[n-1].any = replaced_any;
         replaced_any = 1'b0;
      end
      for (k = 0; k < n; k++) rewrite_q.push_back(step_out[k]);
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("MISMATCH t=%0t %s: got %h want %h", $realtime, what, got, want);
      mismatch_count = mismatch_count + 1;
   endtask

   task automatic check_result();
      rewrite_type want;
      if (rewrite_q.size() == 0) begin
         report_mismatch("item with nothing pending, byte_out", rsp_byte_out, 8'h00);
      end else begin
         want = rewrite_q.pop_front();
         if (rsp_byte_out !== want.data)
            report_mismatch("byte_out", rsp_byte_out, want.data);
         if (rsp_byte_present !== want.present)
            report_mismatch("byte_present", 8'(rsp_byte_present), 8'(want.present));
         if (rsp_final_result !== want.last)
            report_mismatch("final_result", 8'(rsp_final_result), 8'(want.last));
         if (rsp_any_replaced !== want.any)
            report_mismatch("any_replaced", 8'(rsp_any_replaced), 8'(want.any));
      end
   endtask

   // Track register writes, accepted bytes and delivered items in edge order
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_wdata);
         if (req_valid && !req_stall) predict_rewrite(req_byte_in, req_end_of_text);
         if (rsp_valid && !rsp_stall) check_result();
      end
   end

   // Present one item and hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic eot);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input bit close_stream);
      int i;
      for (i = 0; i < text_buf.size(); i++)
         send_byte(text_buf[i], close_stream && (i == text_buf.size() - 1));
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_setup(input logic [63:0] mlo, input logic [63:0] mhi,
                             input logic [4:0] mlen, input logic [63:0] slo,
                             input logic [63:0] shi, input logic [4:0] slen);
      write_csr(cfrs_pkg::CsrMatchLo, mlo);
      write_csr(cfrs_pkg::CsrMatchHi, mhi);
      write_csr(cfrs_pkg::CsrMatchLen, {59'd0, mlen});
      write_csr(cfrs_pkg::CsrSwapLo, slo);
      write_csr(cfrs_pkg::CsrSwapHi, shi);
      write_csr(cfrs_pkg::CsrSwapLen, {59'd0, slen});
      csr_valid <= 1'b0;
   endtask

   // Drop valid, drain every pending item, then let the back end go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (rewrite_q.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic test_pass_through();
      text_buf = '{8'h00, 8'hFF};
      send_text(1'b1);
      settle();
   endtask

   // Letters fold, neighbors of the letter range do not
   task automatic test_caseless_match();
      load_setup(64'h5B4071, 64'd0, 5'd3, 64'h217A5978, 64'd0, 5'd4);
      text_buf = '{8'h51, 8'h40, 8'h5B, 8'h71, 8'h60, 8'h7B};
      send_text(1'b1);
      settle();
   endtask

   // Oversized lengths clamp to a full sixteen-byte pattern and replacement
   task automatic test_saturated_lengths();
      logic [63:0] mlo;
      logic [63:0] mhi;
      int          k;
      mlo = 64'h7A417A417A417A41;
      mhi = 64'h5A615A615A615A61;
      load_setup(mlo, mhi, 5'd31, 64'h80FF7F0001020408, 64'hFFFEFDFC10204000, 5'd31);
      text_buf.delete();
      for (k = 0; k < 16; k++) text_buf.push_back(byte_lane(mlo, mhi, k) ^ 8'h20);
      send_text(1'b1);
      settle();
   endtask

   // A match on the last byte with an empty replacement leaves only the marker
   task automatic test_empty_final();
      load_setup(64'h78, 64'd0, 5'd1, 64'd0, 64'd0, 5'd0);
      text_buf = '{8'h58};
      send_text(1'b1);
      settle();
   endtask

   // A new pattern length discards the partly filled window
   task automatic test_length_write_mid_stream();
      load_setup(64'h636261, 64'd0, 5'd3, 64'h23, 64'd0, 5'd1);
      text_buf = '{8'h61, 8'h62};
      send_text(1'b0);
      settle();
      write_csr(cfrs_pkg::CsrMatchLen, 64'd2);
      csr_valid <= 1'b0;
      text_buf = '{8'h41, 8'h42};
      send_text(1'b1);
      settle();
   endtask

   task automatic random_setup(input int slot);
      logic [63:0] mlo;
      logic [63:0] mhi;
      logic [4:0]  mlen;
      logic [4:0]  slen;
      int          k;
      for (k = 0; k < 8; k++) begin
         mlo[8*k +: 8] = pick_byte(20);
         mhi[8*k +: 8] = pick_byte(20);
      end
      case (slot)
         0: begin
            mlen = 5'($urandom_range(17, 31));
            slen = 5'($urandom_range(0, 31));
         end
         1: begin
            mlen = 5'd1;
            slen = 5'd0;
         end
         2: begin
            mlen = 5'($urandom_range(2, 5));
            slen = 5'd16;
         end
         3: begin
            mlen = 5'd0;
            slen = 5'($urandom_range(0, 31));
         end
         4: begin
            mlen = 5'd16;
            slen = 5'($urandom_range(17, 31));
         end
         default: begin
            mlen = 5'($urandom_range(2, 8));
            slen = 5'($urandom_range(1, 8));
         end
      endcase
      load_setup(mlo, mhi, mlen, {$urandom(), $urandom()}, {$urandom(), $urandom()}, slen);
   endtask

   // Build one stream: pattern copies, broken prefixes and noise
   task automatic build_text();
      int plen;
      int pieces;
      int p;
      int k;
      int n;
      int r;
      plen = (pat_len_reg > PatCap) ? PatCap : int'(pat_len_reg);
      text_buf.delete();
      pieces = $urandom_range(1, 4);
      for (p = 0; p < pieces; p++) begin
         r = $urandom_range(0, 99);
         if (plen > 0 && r < 55) begin
            for (k = 0; k < plen; k++)
               text_buf.push_back(vary_case(byte_lane(pat_lo, pat_hi, k)));
         end else if (plen > 1 && r < 75) begin
            n = $urandom_range(1, plen - 1);
            for (k = 0; k < n; k++)
               text_buf.push_back(vary_case(byte_lane(pat_lo, pat_hi, k)));
         end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) text_buf.push_back(pick_byte(50));
         end
      end
   endtask

   task automatic test_random_text(input int slot, input int src_pct, input int dst_pct);
      int c;
      int sent;
      idle_pct = src_pct;
      stall_pct = dst_pct;
      for (c = 0; c < 2; c++) begin
         random_setup(slot + c);
         sent = 0;
         while (sent < 25) begin
            build_text();
            send_text(1'b1);
            sent = sent + text_buf.size();
         end
         settle();
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_pass_through();
      test_caseless_match();
      test_saturated_lengths();
      test_empty_final();
      test_length_write_mid_stream();
      test_random_text(0, 33, 66);
      test_random_text(2, 66, 33);
      test_random_text(4, 0, 0);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("caseless_find_replace_stream_core verification clean");
      end else begin
         $display("caseless_find_replace_stream_core verification failed");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run
   initial begin
      #4000000;
      $display("caseless_find_replace_stream_core verification failed");
      $finish;
   end

endmodule

### caseless_find_replace_stream_core.f
+incdir+rtl/core
rtl/core/cfrs_pkg.sv
rtl/core/cfrs_front.sv
rtl/core/cfrs_queue.sv
rtl/core/cfrs_back.sv
rtl/core/caseless_find_replace_stream_core.sv
tb/sv/tb_caseless_find_replace_stream_core.sv
